FILE: rtl/rlim_pkg.sv
// Shared constants and types of the per-user sliding-window rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package rlim_pkg;

    localparam int NUM_USERS = 256;
    localparam int MAX_SLOTS = 16;

    localparam int USER_W    = 8;
    localparam int STAMP_W   = 32;
    localparam int WIN_W     = 31;
    localparam int LIM_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int ROW_W     = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam int CNT_W     = ($clog2(MAX_SLOTS + 1) > CNT_OUT_W) ?
                               $clog2(MAX_SLOTS + 1) : CNT_OUT_W;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef logic [MAX_SLOTS-1:0][STAMP_W-1:0] t_stamp_row;

    typedef struct packed {
        logic             limit_enable;
        logic [LIM_W-1:0] max_per_window;
        logic [WIN_W-1:0] window_ms;
    } t_cfg;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic                 en;
        logic [ROW_W-1:0]     addr;
        t_stamp_row           stamps;
        logic [MAX_SLOTS-1:0] valid;
    } t_wr_req;

endpackage
`default_nettype wire

FILE: rtl/per_user_sliding_window_rate_limiter.sv
// Per-user sliding-window rate limiter: request intake, row evaluation and result output.
//
// Usage: each input beat on s_axis carries a user index and the current time in ms.
// The block reads that user's row of logged stamps, drops stale ones, counts the
// rest and answers with one beat on m_axis: allowed and the fresh count before
// the request. An allowed request logs its time in the lowest free slot.
// With limiting on, a beat passes the memory read, the age compare over the row, count
// and write-back, and the output register; with limiting off it goes straight to the
// output register, and the row is not touched. One request is in work at a time: a new
// beat is taken only once the last result has been loaded into the output register.
// A finished result waits in the output register; the next request is taken
// meanwhile, and its result holds in the block until m_axis_tready frees the register.
// Reset clears the control state, the row valid flops (all users start with an
// empty log) and restores limit_enable=1, max_per_window=10, window_ms=60000. No
// clearing pass is needed after reset. Configuration must go through the APB port
// while the block is idle; the block itself does not enforce this. pready is always 1.
`timescale 1ns / 1ps
`default_nettype none
module per_user_sliding_window_rate_limiter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] user_index, [39:8] now_ms
    input  wire logic [39:0]                        s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] allowed, [5:1] recent_count, [7:6] zero
    output logic [7:0]                              m_axis_tdata,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rlim_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [rlim_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [rlim_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready
);
    import rlim_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [CNT_W-1:0]     CNT_SAT   = CNT_W'({CNT_OUT_W{1'b1}});
    localparam logic [CNT_W-1:0]     SLOTS_CNT = CNT_W'(MAX_SLOTS);

    t_cfg                  cfg;
    t_rd_req               rd_req;
    t_wr_req               wr_req;
    t_stamp_row            rd_stamps;
    logic [MAX_SLOTS-1:0]  rd_valid;

    logic [1:0]            r_state, n_state;
    logic [ROW_W-1:0]      r_row;
    logic [STAMP_W-1:0]    r_now;
    logic [MAX_SLOTS-1:0]  r_fresh;
    logic                  r_res_allowed;
    logic [CNT_OUT_W-1:0]  r_res_count;
    logic                  r_out_valid;
    logic                  r_out_allowed;
    logic [CNT_OUT_W-1:0]  r_out_count;

    logic                  in_accept;
    logic                  out_free;
    logic [USER_W-1:0]     in_user;
    logic [STAMP_W-1:0]    in_now;
    logic [MAX_SLOTS-1:0]  fresh;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      limit;
    logic [MAX_SLOTS-1:0]  free_oh;
    logic                  any_free;
    logic                  allow;
    logic [CNT_OUT_W-1:0]  count_sat;

    rlim_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rlim_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (rd_req),
        .i_wr        (wr_req),
        .o_rd_stamps (rd_stamps),
        .o_rd_valid  (rd_valid)
    );

    assign in_user       = s_axis_tdata[USER_W-1:0];
    assign in_now        = s_axis_tdata[USER_W +: STAMP_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~r_out_valid | m_axis_tready;

    assign rd_req.en   = in_accept & cfg.limit_enable;
    assign rd_req.addr = in_user[ROW_W-1:0];

    always_comb begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
            fresh[s] = rd_valid[s] &
                       ((r_now - rd_stamps[s]) <= {1'b0, cfg.window_ms});
        end
    end

    always_comb begin
        count = '0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            count = count + CNT_W'(r_fresh[s]);
        end
    end

    assign limit     = (CNT_W'(cfg.max_per_window) > SLOTS_CNT) ?
                       SLOTS_CNT : CNT_W'(cfg.max_per_window);
    assign free_oh   = ~r_fresh & (r_fresh + MAX_SLOTS'(1));
    assign any_free  = ~&r_fresh;
    assign allow     = (count < limit) & any_free;
    assign count_sat = (count > CNT_SAT) ? {CNT_OUT_W{1'b1}} : count[CNT_OUT_W-1:0];

    assign wr_req.en    = (r_state == S_DEC);
    assign wr_req.addr  = r_row;
    assign wr_req.valid = r_fresh | (allow ? free_oh : '0);
    always_comb begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
            wr_req.stamps[s] = (allow & free_oh[s]) ? r_now : rd_stamps[s];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = cfg.limit_enable ? S_EVAL : S_OUT;
                end
            end
            S_EVAL: n_state = S_DEC;
            S_DEC:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_row         <= in_user[ROW_W-1:0];
            r_now         <= in_now;
            r_res_allowed <= 1'b1;
            r_res_count   <= '0;
        end
        if (r_state == S_EVAL) begin
            r_fresh <= fresh;
        end
        if (r_state == S_DEC) begin
            r_res_allowed <= allow;
            r_res_count   <= count_sat;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_allowed <= r_res_allowed;
            r_out_count   <= r_res_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_count, r_out_allowed};

`ifndef SYNTHESIS
    a_write_only_in_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> (r_state == S_DEC))
        else $error("row write outside the decide step");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted beat did not start work");

    a_enabled_reads_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && cfg.limit_enable) |=> (r_state == S_EVAL))
        else $error("enabled request skipped the row read");

    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not presented");
`endif

endmodule
`default_nettype wire

FILE: rtl/rlim_cfg.sv
// APB configuration registers of the rate limiter.
`timescale 1ns / 1ps
`default_nettype none
module rlim_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rlim_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [rlim_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [rlim_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output rlim_pkg::t_cfg                          o_cfg
);
    import rlim_pkg::*;

    localparam logic [1:0] REG_LIMIT_ENABLE   = 2'd0;
    localparam logic [1:0] REG_MAX_PER_WINDOW = 2'd1;
    localparam logic [1:0] REG_WINDOW_MS      = 2'd2;

    t_cfg       r_cfg;
    logic       wr_hit;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_hit  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit_enable   <= 1'b1;
            r_cfg.max_per_window <= LIM_W'(10);
            r_cfg.window_ms      <= WIN_W'(60000);
        end else if (wr_hit) begin
            unique case (reg_idx)
                REG_LIMIT_ENABLE:   r_cfg.limit_enable   <= pwdata[0];
                REG_MAX_PER_WINDOW: r_cfg.max_per_window <= pwdata[LIM_W-1:0];
                REG_WINDOW_MS:      r_cfg.window_ms      <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LIMIT_ENABLE:   prdata = CFG_DATA_W'(r_cfg.limit_enable);
            REG_MAX_PER_WINDOW: prdata = CFG_DATA_W'(r_cfg.max_per_window);
            REG_WINDOW_MS:      prdata = CFG_DATA_W'(r_cfg.window_ms);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: rtl/rlim_store.sv
// Row memories of stamps and slot marks, with a per-row valid flop.
`timescale 1ns / 1ps
`default_nettype none
module rlim_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rlim_pkg::t_rd_req             i_rd,
    input  wire rlim_pkg::t_wr_req             i_wr,
    output rlim_pkg::t_stamp_row               o_rd_stamps,
    output logic [rlim_pkg::MAX_SLOTS-1:0]     o_rd_valid
);
    import rlim_pkg::*;

    t_stamp_row           r_stamp_mem [NUM_USERS];
    logic [MAX_SLOTS-1:0] r_mark_mem  [NUM_USERS];
    logic [NUM_USERS-1:0] r_row_valid;

    t_stamp_row           r_rd_stamps;
    logic [MAX_SLOTS-1:0] r_rd_marks;
    logic                 r_rd_row_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_stamp_mem[i_wr.addr] <= i_wr.stamps;
            r_mark_mem[i_wr.addr]  <= i_wr.valid;
        end
        if (i_rd.en) begin
            r_rd_stamps <= r_stamp_mem[i_rd.addr];
            r_rd_marks  <= r_mark_mem[i_rd.addr];
            r_rd_row_ok <= r_row_valid[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_wr.en) begin
            r_row_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_stamps = r_rd_stamps;
    assign o_rd_valid  = r_rd_row_ok ? r_rd_marks : '0;

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the per-user sliding-window rate limiter.
`timescale 1ns / 1ps
module testbench;
    import rlim_pkg::*;

    localparam int ENTRIES     = NUM_USERS * MAX_SLOTS;
    localparam int LATENCY_PAD = 8;
    localparam int RANDOM_BEATS = 330;
    localparam int PHASES      = 6;
    localparam int SCRIPT_ROWS = 31;

    localparam logic [CFG_ADDR_W-1:0] ADDR_LIMIT_ENABLE   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_PER_WINDOW = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_MS      = 4'd8;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} t_row_kind;
    typedef enum logic {CHK_PREDICTED, CHK_FIXED} t_row_check;

    typedef struct packed {
        logic       allowed;
        logic [4:0] recent_count;
    } t_verdict;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
        logic [7:0]            user;
        logic [31:0]           now;
        t_row_check            check;
        t_verdict              fixed;
    } t_script_row;

    typedef struct {
        logic        enable;
        logic [4:0]  max_per_window;
        logic [30:0] window;
        int          crowd_size;
    } t_phase_cfg;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] user_index, [39:8] now_ms
    logic [39:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] allowed, [5:1] recent_count, [7:6] zero
    logic [7:0]            m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    per_user_sliding_window_rate_limiter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    logic [31:0] logged_stamp [ENTRIES];
    bit          stamp_live [ENTRIES];
    logic        cfg_enable;
    logic [4:0]  cfg_max;
    logic [30:0] cfg_window;

    t_verdict    pending_verdicts [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    function automatic t_verdict judge_request(input logic [7:0] user, input logic [31:0] now);
        int unsigned base;
        int unsigned count;
        int unsigned lim;
        int unsigned free_idx;
        bit          have_free;
        t_verdict    v;
        v = '{allowed: 1'b1, recent_count: 5'd0};
        if (!cfg_enable) begin
            return v;
        end
        base = (user % NUM_USERS) * MAX_SLOTS;
        count = 0;
        have_free = 1'b0;
        free_idx = 0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (stamp_live[base + s] && (now - logged_stamp[base + s]) > {1'b0, cfg_window}) begin
                stamp_live[base + s] = 1'b0;
            end
            if (stamp_live[base + s]) begin
                count++;
            end else if (!have_free) begin
                have_free = 1'b1;
                free_idx = base + s;
            end
        end
        lim = (cfg_max > MAX_SLOTS) ? MAX_SLOTS : cfg_max;
        v.recent_count = (count > 31) ? 5'd31 : count[4:0];
        if (count >= lim || !have_free) begin
            v.allowed = 1'b0;
        end else begin
            logged_stamp[free_idx] = now;
            stamp_live[free_idx] = 1'b1;
        end
        return v;
    endfunction

    function automatic t_script_row ask(input logic [7:0] user, input logic [31:0] now);
        return '{ROW_REQUEST, '0, '0, user, now, CHK_PREDICTED, '0};
    endfunction

    function automatic t_script_row ask_fixed(input logic [7:0] user, input logic [31:0] now,
                                              input logic allowed, input logic [4:0] count);
        return '{ROW_REQUEST, '0, '0, user, now, CHK_FIXED, '{allowed, count}};
    endfunction

    function automatic t_script_row poke(input logic [CFG_ADDR_W-1:0] addr,
                                         input logic [CFG_DATA_W-1:0] value);
        return '{ROW_WRITE, addr, value, '0, '0, CHK_PREDICTED, '0};
    endfunction

    task automatic send_request(input logic [7:0] user, input logic [31:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {now, user};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        unique case (addr)
            ADDR_LIMIT_ENABLE:   cfg_enable = value[0];
            ADDR_MAX_PER_WINDOW: cfg_max = value[4:0];
            ADDR_WINDOW_MS:      cfg_window = value[30:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no request outstanding");
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.allowed) begin
                    $error("allowed: expected %0d, got %0d", want.allowed, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[5:1] !== want.recent_count) begin
                    $error("recent_count: expected %0d, got %0d",
                           want.recent_count, m_axis_tdata[5:1]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_script_row script [SCRIPT_ROWS];
        t_phase_cfg  phase_plan [PHASES];
        logic [7:0]  crowd [8];
        logic [7:0]  user;
        logic [31:0] now;
        int unsigned step_max;
        int unsigned lim;
        int unsigned pick;
        t_verdict    v;

        for (int e = 0; e < ENTRIES; e++) begin
            stamp_live[e] = 1'b0;
            logged_stamp[e] = '0;
        end
        cfg_enable = 1'b1;
        cfg_max = 5'd10;
        cfg_window = 31'd60000;

        script = '{
            ask_fixed(8'd0, 32'd0, 1'b1, 5'd0),
            ask_fixed(8'd0, 32'd0, 1'b1, 5'd1),
            ask_fixed(8'd255, 32'hFFFF_FFFF, 1'b1, 5'd0),
            ask(8'd255, 32'd5),
            ask(8'd0, 32'd60000),
            ask(8'd0, 32'd60001),
            ask(8'd255, 32'd0),
            poke(ADDR_MAX_PER_WINDOW, 32'd0),
            ask_fixed(8'd7, 32'd100, 1'b0, 5'd0),
            ask(8'd0, 32'd60001),
            poke(ADDR_MAX_PER_WINDOW, 32'd2),
            poke(ADDR_WINDOW_MS, 32'd0),
            ask_fixed(8'd9, 32'd500, 1'b1, 5'd0),
            ask_fixed(8'd9, 32'd500, 1'b1, 5'd1),
            ask_fixed(8'd9, 32'd500, 1'b0, 5'd2),
            ask(8'd9, 32'd501),
            poke(ADDR_WINDOW_MS, 32'd100),
            ask(8'd3, 32'd1000),
            ask(8'd3, 32'd1100),
            ask(8'd3, 32'd1101),
            ask(8'd3, 32'd1102),
            poke(ADDR_MAX_PER_WINDOW, 32'd31),
            poke(ADDR_WINDOW_MS, 32'h7FFF_FFFF),
            ask(8'd128, 32'h8000_0000),
            ask(8'd128, 32'd0),
            poke(ADDR_LIMIT_ENABLE, 32'd0),
            ask_fixed(8'd3, 32'd1102, 1'b1, 5'd0),
            ask_fixed(8'd170, 32'hAAAA_AAAA, 1'b1, 5'd0),
            ask_fixed(8'd85, 32'h5555_5555, 1'b1, 5'd0),
            poke(ADDR_LIMIT_ENABLE, 32'd1),
            ask(8'd3, 32'd1102)
        };

        phase_plan[0] = '{1'b1, 5'd10, 31'd60000, 8};
        phase_plan[1] = '{1'b1, 5'd31, 31'h7FFF_FFFF, 4};
        phase_plan[2] = '{1'b1, 5'd1, 31'd1, 4};
        phase_plan[3] = '{1'b0, 5'd16, 31'd1000, 8};
        phase_plan[4] = '{1'b1, 5'd16, 31'd5000, 6};
        phase_plan[5] = '{1'b1, 5'($urandom_range(1, 15)), 31'($urandom_range(2, 20000)), 5};

        send_idle_pct = 24;
        stall_pct = 85;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            if (script[r].kind == ROW_WRITE) begin
                drain_results();
                write_reg(script[r].addr, script[r].wdata);
            end else begin
                send_request(script[r].user, script[r].now);
                v = judge_request(script[r].user, script[r].now);
                pending_verdicts.push_back(script[r].check == CHK_FIXED ? script[r].fixed : v);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            send_idle_pct = (p < 2) ? 24 : (p < 4) ? 85 : 0;
            stall_pct = (p < 2) ? 85 : (p < 4) ? 24 : 0;
            write_reg(ADDR_LIMIT_ENABLE, {31'd0, phase_plan[p].enable});
            write_reg(ADDR_MAX_PER_WINDOW, {27'd0, phase_plan[p].max_per_window});
            write_reg(ADDR_WINDOW_MS, {1'b0, phase_plan[p].window});
            lim = (cfg_max > MAX_SLOTS) ? MAX_SLOTS : cfg_max;
            if (lim == 0) begin
                lim = 1;
            end
            step_max = (cfg_window / (phase_plan[p].crowd_size * lim)) * 2 + 1;
            foreach (crowd[k]) begin
                crowd[k] = 8'($urandom_range(0, 255));
            end
            now = $urandom;
            for (int n = 0; n < RANDOM_BEATS; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    user = crowd[$urandom_range(0, phase_plan[p].crowd_size - 1)];
                end else begin
                    user = 8'($urandom_range(0, 255));
                end
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    now = now + $urandom_range(0, step_max);
                end else if (pick == 8) begin
                    now = now - $urandom_range(1, step_max);
                end else if (pick == 9) begin
                    now = $urandom;
                end
                send_request(user, now);
                pending_verdicts.push_back(judge_request(user, now));
            end
        end

        drain_results();
        if (error_count == 0 && pending_verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
